### rtl/sbpp_pkg.sv
// ----------------------------------------------------------------------------
// sbpp_pkg: shared types, constants and fixed-point helpers
// Formats, record layouts and rounding/saturation functions used by the
// shearing-box particle push datapath, its response queue and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sbpp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COEF_WIDTH = 32;
   localparam int FRAC_BITS = 24;
   localparam int INDEX_WIDTH = 10;
   localparam int MAX_PARTICLES = 1024;
   localparam int ADDR_WIDTH = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int PROD_WIDTH = VALUE_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH = PROD_WIDTH + 3;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int MODE_WIDTH = 3;
   localparam int MODE_BIT_SBOX = 0;
   localparam int MODE_BIT_3D = 1;
   localparam int MODE_BIT_STRAT = 2;

   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int CREDIT_WIDTH = $clog2(FIFO_DEPTH + 1);
   localparam int SETTLE_WIDTH = 2;
   localparam int SETTLE_CYCLES = 2;

   localparam int LANES = 6;
   localparam int TERMS = 4;
   localparam int LANE_POS_X = 0;
   localparam int LANE_POS_Y = 1;
   localparam int LANE_POS_Z = 2;
   localparam int LANE_VEL_X = 3;
   localparam int LANE_VEL_Y = 4;
   localparam int LANE_VEL_Z = 5;
   localparam int TERM_CURRENT = 0;
   localparam int TERM_SAVED = 1;
   localparam int TERM_STEP = 2;
   localparam int TERM_HISTORY = 3;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [COEF_WIDTH-1:0] coef_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [SUM_WIDTH-1:0] wide_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;

   localparam coef_type COEF_CURRENT_RESET = coef_type'(2 ** FRAC_BITS);
   localparam coef_type SHEAR_PARAM_RESET = coef_type'(3 * (2 ** (FRAC_BITS - 1)));
   localparam logic [MODE_WIDTH-1:0] MODE_RESET = MODE_WIDTH'(1 << MODE_BIT_3D);
   localparam logic signed [COEF_WIDTH:0] TWO_FIXED = (COEF_WIDTH + 1)'(2 * (2 ** FRAC_BITS));
   localparam wide_type ROUND_HALF = wide_type'(2 ** (FRAC_BITS - 1));

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_COEF_CURRENT = 4'd0,
      REG_COEF_SAVED = 4'd1,
      REG_STEP_COEF = 4'd2,
      REG_HISTORY_COEF = 4'd3,
      REG_ROTATION_RATE = 4'd4,
      REG_SHEAR_PARAM = 4'd5,
      REG_MODE_FLAGS = 4'd6,
      REG_CAPTURE = 4'd7
   } csr_reg_type;

   typedef struct packed {
      index_type index;
      value_type pos_x;
      value_type pos_y;
      value_type pos_z;
      value_type vel_x;
      value_type vel_y;
      value_type vel_z;
      value_type drag_x;
      value_type drag_y;
      value_type drag_z;
   } item_type;

   typedef struct packed {
      value_type pos_x;
      value_type pos_y;
      value_type pos_z;
      value_type vel_x;
      value_type vel_y;
      value_type vel_z;
   } saved_type;

   typedef struct packed {
      index_type index;
      value_type pos_x;
      value_type pos_y;
      value_type pos_z;
      value_type vel_x;
      value_type vel_y;
      value_type vel_z;
   } result_type;

   typedef struct packed {
      coef_type cur;
      coef_type saved;
      coef_type step;
      coef_type hist;
      coef_type cor;
      coef_type shr;
      coef_type grav;
      coef_type drift;
      logic sbox;
      logic three_d;
      logic strat;
   } ctrl_type;

   // Round half up of a Q.24 fraction, keeping the wide format.
   function automatic wide_type round_frac(input wide_type v);
      return (v + ROUND_HALF) >>> FRAC_BITS;
   endfunction

   function automatic value_type sat_value(input wide_type v);
      value_type r;
      logic fits;
      fits = (v[SUM_WIDTH-1:VALUE_WIDTH-1] == {(SUM_WIDTH - VALUE_WIDTH + 1){v[SUM_WIDTH-1]}});
      if (fits) begin
         r = v[VALUE_WIDTH-1:0];
      end else if (v[SUM_WIDTH-1]) begin
         r = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
      end else begin
         r = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
      end
      return r;
   endfunction

   function automatic coef_type sat_coef(input wide_type v);
      coef_type r;
      logic fits;
      fits = (v[SUM_WIDTH-1:COEF_WIDTH-1] == {(SUM_WIDTH - COEF_WIDTH + 1){v[SUM_WIDTH-1]}});
      if (fits) begin
         r = v[COEF_WIDTH-1:0];
      end else if (v[SUM_WIDTH-1]) begin
         r = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
      end else begin
         r = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/sbpp_datapath.sv
// ----------------------------------------------------------------------------
// sbpp_datapath: force and Runge-Kutta weighting pipeline
// Five register stages: force products, rounded forces, shear drift, the
// weighted lane products and pairwise sums; the final sum is rounded and
// saturated on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sbpp_pkg::item_type     in_item,
   input  sbpp_pkg::saved_type    in_saved,
   input  sbpp_pkg::ctrl_type     ctrl,
   output logic                   out_valid,
   output sbpp_pkg::result_type   out_result
);
   import sbpp_pkg::*;

   logic       d1_valid_ff;
   item_type   d1_item_ff;
   saved_type  d1_saved_ff;
   prod_type   d1_cor_ff;
   prod_type   d1_shr_ff;
   prod_type   d1_grav_ff;
   prod_type   d1_drift_ff;
   value_type  cor_src;

   logic       d2_valid_ff;
   item_type   d2_item_ff;
   saved_type  d2_saved_ff;
   value_type  d2_fx_ff;
   value_type  d2_fy_ff;
   value_type  d2_fz_ff;
   value_type  d2_drift_ff;
   value_type  f_cor;
   value_type  f_shr;
   value_type  f_grav;

   logic       d3_valid_ff;
   item_type   d3_item_ff;
   saved_type  d3_saved_ff;
   value_type  d3_fx_ff;
   value_type  d3_fy_ff;
   value_type  d3_fz_ff;
   value_type  d3_ydot_ff;

   logic       d4_valid_ff;
   index_type  d4_index_ff;
   value_type  d4_pos_z_ff;
   prod_type   d4_prod_ff [LANES][TERMS];
   prod_type   prod_in [LANES][TERMS];
   value_type  lane_val [LANES][TERMS];
   coef_type   lane_coef [TERMS];

   logic       d5_valid_ff;
   index_type  d5_index_ff;
   value_type  d5_pos_z_ff;
   wide_type   d5_pair_ff [LANES][2];
   value_type  lane_out [LANES];

   // Stage 1: products of the derived coefficients with the particle state.
   assign cor_src = ctrl.three_d ? in_item.vel_y : in_item.vel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= 1'b0;
      end else begin
         d1_valid_ff <= in_valid;
      end
      d1_item_ff <= in_item;
      d1_saved_ff <= in_saved;
      d1_cor_ff <= ctrl.cor * cor_src;
      d1_shr_ff <= ctrl.shr * in_item.vel_x;
      d1_grav_ff <= ctrl.grav * in_item.pos_z;
      d1_drift_ff <= ctrl.drift * in_item.pos_x;
   end

   // Stage 2: round and saturate the forces and the drift term.
   assign f_cor = sat_value(round_frac(wide_type'(d1_cor_ff)));
   assign f_shr = sat_value(round_frac(wide_type'(d1_shr_ff)));
   assign f_grav = sat_value(round_frac(wide_type'(d1_grav_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_valid_ff <= 1'b0;
      end else begin
         d2_valid_ff <= d1_valid_ff;
      end
      d2_item_ff <= d1_item_ff;
      d2_saved_ff <= d1_saved_ff;
      d2_fx_ff <= ctrl.sbox ? f_cor : '0;
      d2_fy_ff <= (ctrl.sbox && ctrl.three_d) ? f_shr : '0;
      if (!ctrl.sbox) begin
         d2_fz_ff <= '0;
      end else if (!ctrl.three_d) begin
         d2_fz_ff <= f_shr;
      end else begin
         d2_fz_ff <= ctrl.strat ? f_grav : '0;
      end
      d2_drift_ff <= sat_value(round_frac(wide_type'(d1_drift_ff)));
   end

   // Stage 3: azimuthal drift velocity including the background shear.
   always_ff @(posedge clock) begin
      if (reset) begin
         d3_valid_ff <= 1'b0;
      end else begin
         d3_valid_ff <= d2_valid_ff;
      end
      d3_item_ff <= d2_item_ff;
      d3_saved_ff <= d2_saved_ff;
      d3_fx_ff <= d2_fx_ff;
      d3_fy_ff <= d2_fy_ff;
      d3_fz_ff <= d2_fz_ff;
      if (ctrl.sbox && ctrl.three_d) begin
         d3_ydot_ff <= sat_value(wide_type'(d2_item_ff.vel_y) - wide_type'(d2_drift_ff));
      end else begin
         d3_ydot_ff <= d2_item_ff.vel_y;
      end
   end

   // Stage 4: the four weighted terms of every lane.
   always_comb begin
      lane_coef[TERM_CURRENT] = ctrl.cur;
      lane_coef[TERM_SAVED] = ctrl.saved;
      lane_coef[TERM_STEP] = ctrl.step;
      lane_coef[TERM_HISTORY] = ctrl.hist;

      lane_val[LANE_POS_X][TERM_CURRENT] = d3_item_ff.pos_x;
      lane_val[LANE_POS_X][TERM_SAVED] = d3_saved_ff.pos_x;
      lane_val[LANE_POS_X][TERM_STEP] = d3_item_ff.vel_x;
      lane_val[LANE_POS_X][TERM_HISTORY] = '0;
      lane_val[LANE_POS_Y][TERM_CURRENT] = d3_item_ff.pos_y;
      lane_val[LANE_POS_Y][TERM_SAVED] = d3_saved_ff.pos_y;
      lane_val[LANE_POS_Y][TERM_STEP] = d3_ydot_ff;
      lane_val[LANE_POS_Y][TERM_HISTORY] = '0;
      lane_val[LANE_POS_Z][TERM_CURRENT] = d3_item_ff.pos_z;
      lane_val[LANE_POS_Z][TERM_SAVED] = d3_saved_ff.pos_z;
      lane_val[LANE_POS_Z][TERM_STEP] = d3_item_ff.vel_z;
      lane_val[LANE_POS_Z][TERM_HISTORY] = '0;
      lane_val[LANE_VEL_X][TERM_CURRENT] = d3_item_ff.vel_x;
      lane_val[LANE_VEL_X][TERM_SAVED] = d3_saved_ff.vel_x;
      lane_val[LANE_VEL_X][TERM_STEP] = d3_fx_ff;
      lane_val[LANE_VEL_X][TERM_HISTORY] = d3_item_ff.drag_x;
      lane_val[LANE_VEL_Y][TERM_CURRENT] = d3_item_ff.vel_y;
      lane_val[LANE_VEL_Y][TERM_SAVED] = d3_saved_ff.vel_y;
      lane_val[LANE_VEL_Y][TERM_STEP] = d3_fy_ff;
      lane_val[LANE_VEL_Y][TERM_HISTORY] = d3_item_ff.drag_y;
      lane_val[LANE_VEL_Z][TERM_CURRENT] = d3_item_ff.vel_z;
      lane_val[LANE_VEL_Z][TERM_SAVED] = d3_saved_ff.vel_z;
      lane_val[LANE_VEL_Z][TERM_STEP] = d3_fz_ff;
      lane_val[LANE_VEL_Z][TERM_HISTORY] = d3_item_ff.drag_z;

      for (int l = 0; l < LANES; l++) begin
         for (int t = 0; t < TERMS; t++) begin
            prod_in[l][t] = lane_coef[t] * lane_val[l][t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d4_valid_ff <= 1'b0;
      end else begin
         d4_valid_ff <= d3_valid_ff;
      end
      d4_index_ff <= d3_item_ff.index;
      d4_pos_z_ff <= d3_item_ff.pos_z;
      d4_prod_ff <= prod_in;
   end

   // Stage 5: pairwise sums of the exact products.
   always_ff @(posedge clock) begin
      if (reset) begin
         d5_valid_ff <= 1'b0;
      end else begin
         d5_valid_ff <= d4_valid_ff;
      end
      d5_index_ff <= d4_index_ff;
      d5_pos_z_ff <= d4_pos_z_ff;
      for (int l = 0; l < LANES; l++) begin
         d5_pair_ff[l][0] <= wide_type'(d4_prod_ff[l][TERM_CURRENT])
                             + wide_type'(d4_prod_ff[l][TERM_SAVED]);
         d5_pair_ff[l][1] <= wide_type'(d4_prod_ff[l][TERM_STEP])
                             + wide_type'(d4_prod_ff[l][TERM_HISTORY]);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_out[l] = sat_value(round_frac(d5_pair_ff[l][0] + d5_pair_ff[l][1]));
      end
   end

   assign out_valid = d5_valid_ff;
   assign out_result.index = d5_index_ff;
   assign out_result.pos_x = lane_out[LANE_POS_X];
   assign out_result.pos_y = lane_out[LANE_POS_Y];
   assign out_result.pos_z = ctrl.three_d ? lane_out[LANE_POS_Z] : d5_pos_z_ff;
   assign out_result.vel_x = lane_out[LANE_VEL_X];
   assign out_result.vel_y = lane_out[LANE_VEL_Y];
   assign out_result.vel_z = lane_out[LANE_VEL_Z];

endmodule

`default_nettype wire

### rtl/sbpp_rsp_fifo.sv
// ----------------------------------------------------------------------------
// sbpp_rsp_fifo: response queue
// Holds finished results until the response channel takes them, so the
// pipeline never stops while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module sbpp_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sbpp_pkg::result_type  push_data,
   input  logic                  pop,
   output logic                  out_valid,
   output sbpp_pkg::result_type  out_data
);
   import sbpp_pkg::*;

   result_type                 entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0]  wr_ptr_ff;
   logic [FIFO_PTR_WIDTH-1:0]  rd_ptr_ff;
   logic [CREDIT_WIDTH-1:0]    count_ff;
   logic                       do_pop;

   assign out_valid = (count_ff != '0);
   assign out_data = entries_ff[rd_ptr_ff];
   assign do_pop = pop && out_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/shearing_box_particle_push_top.sv
// ----------------------------------------------------------------------------
// shearing_box_particle_push_top: low-storage Runge-Kutta stage for particles.
// Takes one particle per cycle unless requests stall for credits or settling,
// paced by the multiplier pipeline and 16 credits of response queue. Reset
// restores register defaults and empties the pipeline but not the saved-value
// memory. A register write holds off requests while the derived coefficients
// settle.
// ----------------------------------------------------------------------------
`default_nettype none

module shearing_box_particle_push_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  sbpp_pkg::index_type                    req_particle_index,
   input  sbpp_pkg::value_type                    req_pos_x,
   input  sbpp_pkg::value_type                    req_pos_y,
   input  sbpp_pkg::value_type                    req_pos_z,
   input  sbpp_pkg::value_type                    req_vel_x,
   input  sbpp_pkg::value_type                    req_vel_y,
   input  sbpp_pkg::value_type                    req_vel_z,
   input  sbpp_pkg::value_type                    req_drag_x,
   input  sbpp_pkg::value_type                    req_drag_y,
   input  sbpp_pkg::value_type                    req_drag_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output sbpp_pkg::index_type                    rsp_out_index,
   output sbpp_pkg::value_type                    rsp_new_pos_x,
   output sbpp_pkg::value_type                    rsp_new_pos_y,
   output sbpp_pkg::value_type                    rsp_new_pos_z,
   output sbpp_pkg::value_type                    rsp_new_vel_x,
   output sbpp_pkg::value_type                    rsp_new_vel_y,
   output sbpp_pkg::value_type                    rsp_new_vel_z,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [sbpp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [sbpp_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import sbpp_pkg::*;

   coef_type                     coef_current_ff;
   coef_type                     coef_saved_ff;
   coef_type                     step_coef_ff;
   coef_type                     history_coef_ff;
   coef_type                     rotation_rate_ff;
   coef_type                     shear_param_ff;
   logic [MODE_WIDTH-1:0]        mode_flags_ff;
   logic                         capture_ff;
   logic                         csr_write;

   logic signed [COEF_WIDTH:0]   shear_less_two;
   logic signed [2*COEF_WIDTH:0] shr_prod_ff;
   prod_type                     square_prod_ff;
   prod_type                     drift_prod_ff;
   coef_type                     c_cor_ff;
   coef_type                     c_shr_ff;
   coef_type                     c_grav_ff;
   coef_type                     c_drift_ff;
   logic [SETTLE_WIDTH-1:0]      settle_ff;
   ctrl_type                     ctrl;

   logic                         req_accept;
   logic                         rsp_deliver;
   logic                         idx_in_range;
   logic [ADDR_WIDTH-1:0]        req_addr;
   item_type                     req_item;
   saved_type                    req_as_saved;
   saved_type                    saved_mem [MAX_PARTICLES];
   saved_type                    saved_rd_ff;

   logic                         s1_valid_ff;
   item_type                     s1_item_ff;
   logic                         s1_use_input_ff;
   logic                         s1_in_range_ff;
   saved_type                    s1_saved;

   logic                         dp_valid;
   result_type                   dp_result;
   result_type                   rsp_data;
   logic [CREDIT_WIDTH-1:0]      credit_ff;
   logic [CREDIT_WIDTH-1:0]      credit_in;

   // Configuration registers.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_current_ff <= COEF_CURRENT_RESET;
         coef_saved_ff <= '0;
         step_coef_ff <= '0;
         history_coef_ff <= '0;
         rotation_rate_ff <= '0;
         shear_param_ff <= SHEAR_PARAM_RESET;
         mode_flags_ff <= MODE_RESET;
         capture_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_COEF_CURRENT: begin
               coef_current_ff <= coef_type'(csr_data[COEF_WIDTH-1:0]);
            end
            REG_COEF_SAVED: begin
               coef_saved_ff <= coef_type'(csr_data[COEF_WIDTH-1:0]);
            end
            REG_STEP_COEF: begin
               step_coef_ff <= coef_type'(csr_data[COEF_WIDTH-1:0]);
            end
            REG_HISTORY_COEF: begin
               history_coef_ff <= coef_type'(csr_data[COEF_WIDTH-1:0]);
            end
            REG_ROTATION_RATE: begin
               rotation_rate_ff <= coef_type'(csr_data[COEF_WIDTH-1:0]);
            end
            REG_SHEAR_PARAM: begin
               shear_param_ff <= coef_type'(csr_data[COEF_WIDTH-1:0]);
            end
            REG_MODE_FLAGS: begin
               mode_flags_ff <= csr_data[MODE_WIDTH-1:0];
            end
            REG_CAPTURE: begin
               capture_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Derived coefficients: one product stage, then rounding and saturation.
   assign shear_less_two = $signed({shear_param_ff[COEF_WIDTH-1], shear_param_ff}) - TWO_FIXED;

   always_ff @(posedge clock) begin
      shr_prod_ff <= shear_less_two * rotation_rate_ff;
      square_prod_ff <= rotation_rate_ff * rotation_rate_ff;
      drift_prod_ff <= shear_param_ff * rotation_rate_ff;
      c_cor_ff <= sat_coef(wide_type'(rotation_rate_ff) <<< 1);
      c_shr_ff <= sat_coef(round_frac(wide_type'(shr_prod_ff)));
      c_grav_ff <= sat_coef(round_frac(-wide_type'(square_prod_ff)));
      c_drift_ff <= sat_coef(round_frac(wide_type'(drift_prod_ff)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_WIDTH'(SETTLE_CYCLES);
      end else if (csr_write) begin
         settle_ff <= SETTLE_WIDTH'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   assign ctrl.cur = coef_current_ff;
   assign ctrl.saved = coef_saved_ff;
   assign ctrl.step = step_coef_ff;
   assign ctrl.hist = history_coef_ff;
   assign ctrl.cor = c_cor_ff;
   assign ctrl.shr = c_shr_ff;
   assign ctrl.grav = c_grav_ff;
   assign ctrl.drift = c_drift_ff;
   assign ctrl.sbox = mode_flags_ff[MODE_BIT_SBOX];
   assign ctrl.three_d = mode_flags_ff[MODE_BIT_3D];
   assign ctrl.strat = mode_flags_ff[MODE_BIT_STRAT];

   // Request side and credit accounting against the response queue.
   assign req_stall = (credit_ff == CREDIT_WIDTH'(FIFO_DEPTH)) || (settle_ff != '0);
   assign req_accept = req_valid && !req_stall;
   assign rsp_deliver = rsp_valid && !rsp_stall;

   assign credit_in = credit_ff + {{(CREDIT_WIDTH - 1){1'b0}}, req_accept}
                      - {{(CREDIT_WIDTH - 1){1'b0}}, rsp_deliver};

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   assign req_item.index = req_particle_index;
   assign req_item.pos_x = req_pos_x;
   assign req_item.pos_y = req_pos_y;
   assign req_item.pos_z = req_pos_z;
   assign req_item.vel_x = req_vel_x;
   assign req_item.vel_y = req_vel_y;
   assign req_item.vel_z = req_vel_z;
   assign req_item.drag_x = req_drag_x;
   assign req_item.drag_y = req_drag_y;
   assign req_item.drag_z = req_drag_z;

   assign req_as_saved.pos_x = req_pos_x;
   assign req_as_saved.pos_y = req_pos_y;
   assign req_as_saved.pos_z = req_pos_z;
   assign req_as_saved.vel_x = req_vel_x;
   assign req_as_saved.vel_y = req_vel_y;
   assign req_as_saved.vel_z = req_vel_z;

   assign idx_in_range = ({1'b0, req_particle_index} < (INDEX_WIDTH + 1)'(MAX_PARTICLES));
   assign req_addr = req_particle_index[ADDR_WIDTH-1:0];

   // Saved-value memory. With capture on, the incoming values are written and also
   // used directly, since the registered read still returns the old entry.
   always_ff @(posedge clock) begin
      if (req_accept && capture_ff && idx_in_range) begin
         saved_mem[req_addr] <= req_as_saved;
      end
      saved_rd_ff <= saved_mem[req_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_item_ff <= req_item;
         s1_use_input_ff <= capture_ff;
         s1_in_range_ff <= idx_in_range;
      end
   end

   always_comb begin
      if (!s1_in_range_ff) begin
         s1_saved = '0;
      end else if (s1_use_input_ff) begin
         s1_saved.pos_x = s1_item_ff.pos_x;
         s1_saved.pos_y = s1_item_ff.pos_y;
         s1_saved.pos_z = s1_item_ff.pos_z;
         s1_saved.vel_x = s1_item_ff.vel_x;
         s1_saved.vel_y = s1_item_ff.vel_y;
         s1_saved.vel_z = s1_item_ff.vel_z;
      end else begin
         s1_saved = saved_rd_ff;
      end
   end

   sbpp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_item    (s1_item_ff),
      .in_saved   (s1_saved),
      .ctrl       (ctrl),
      .out_valid  (dp_valid),
      .out_result (dp_result)
   );

   sbpp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (dp_valid),
      .push_data (dp_result),
      .pop       (rsp_deliver),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_out_index = rsp_data.index;
   assign rsp_new_pos_x = rsp_data.pos_x;
   assign rsp_new_pos_y = rsp_data.pos_y;
   assign rsp_new_pos_z = rsp_data.pos_z;
   assign rsp_new_vel_x = rsp_data.vel_x;
   assign rsp_new_vel_y = rsp_data.vel_y;
   assign rsp_new_vel_z = rsp_data.vel_z;

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= CREDIT_WIDTH'(FIFO_DEPTH))
      else $error("credit count exceeds response queue depth");

   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> req_stall)
      else $error("request accepted before derived coefficients settled");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> credit_ff != '0)
      else $error("response offered without an outstanding transaction");

   a_push_has_credit: assert property (@(posedge clock) disable iff (reset)
      dp_valid |-> credit_ff != '0)
      else $error("pipeline produced a result without an outstanding transaction");

endmodule

`default_nettype wire
